>>> src/csq_pkg.sv
// Shared types and codes for the counting semaphore with its wait queue.
`default_nettype none

package csq_pkg;

    localparam int THREAD_W = 4;
    localparam int COUNT_W  = 32;

    typedef enum logic [1:0] {
        ACT_SIGNAL    = 2'd0,
        ACT_WAIT      = 2'd1,
        ACT_SUSPEND   = 2'd2,
        ACT_UNSUSPEND = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        EV_RELEASED      = 3'd0,
        EV_BLOCKED       = 3'd1,
        EV_PROCEEDS      = 3'd2,
        EV_SUSPENDED     = 3'd3,
        EV_UNSUSPENDED   = 3'd4,
        EV_NOT_WAITING   = 3'd5,
        EV_NOT_SUSPENDED = 3'd6,
        EV_SIGNAL_DONE   = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        TS_FREE = 2'd0,
        TS_WAIT = 2'd1,
        TS_SUSP = 2'd2
    } thread_st_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REMOVE,
        S_SIG_READ,
        S_SIG_STEP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_REJECT,
        OP_WAIT,
        OP_SUSPEND,
        OP_UNSUSPEND,
        OP_SIG_STEP,
        OP_SIG_DONE
    } op_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [THREAD_W-1:0] thread_id;
        logic [5:0]          signal_amount;
        logic [3:0]          target_state;
    } in_word_t;

    typedef struct packed {
        logic [2:0]                event_res;
        logic [THREAD_W-1:0]       result_thread;
        logic [3:0]                new_state;
        logic signed [COUNT_W-1:0] count_after;
        logic                      last;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load_item;
        logic   load_rem;
        logic   rd_en;
        logic   rd_head;
        op_t    op;
        event_t ev;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t    action;
        logic       in_range;
        thread_st_t thr_st;
        logic       rem_zero;
    } stat_t;

endpackage

`default_nettype wire

>>> src/csq_ctrl.sv
// Sequencing state machine for the semaphore: decodes each word and steps signals.
`default_nettype none

module csq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  csq_pkg::stat_t stat,
    output csq_pkg::cmd_t  cmd
);
    import csq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.action == ACT_SIGNAL)
                begin
                    state_next = S_SIG_READ;
                end
                else if (stat.in_range && stat.action == ACT_SUSPEND &&
                         stat.thr_st == TS_WAIT)
                begin
                    state_next = S_REMOVE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REMOVE:
            begin
                state_next = S_IDLE;
            end
            S_SIG_READ:
            begin
                state_next = stat.rem_zero ? S_IDLE : S_SIG_STEP;
            end
            S_SIG_STEP:
            begin
                state_next = S_SIG_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd.load_item = 1'b0;
        cmd.load_rem  = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_head   = 1'b0;
        cmd.op        = OP_NONE;
        cmd.ev        = EV_NOT_WAITING;
        busy          = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = start;
            end
            S_DECODE:
            begin
                if (stat.action == ACT_SIGNAL)
                begin
                    cmd.load_rem = 1'b1;
                end
                else if (!stat.in_range)
                begin
                    cmd.op = OP_REJECT;
                    cmd.ev = (stat.action == ACT_UNSUSPEND) ? EV_NOT_SUSPENDED
                                                            : EV_NOT_WAITING;
                end
                else
                begin
                    case (stat.action)
                        ACT_WAIT:
                        begin
                            if (stat.thr_st != TS_FREE)
                            begin
                                cmd.op = OP_REJECT;
                                cmd.ev = EV_BLOCKED;
                            end
                            else
                            begin
                                cmd.op = OP_WAIT;
                            end
                        end
                        ACT_SUSPEND:
                        begin
                            if (stat.thr_st != TS_WAIT)
                            begin
                                cmd.op = OP_REJECT;
                                cmd.ev = EV_NOT_WAITING;
                            end
                            else
                            begin
                                cmd.rd_en = 1'b1;
                            end
                        end
                        ACT_UNSUSPEND:
                        begin
                            if (stat.thr_st != TS_SUSP)
                            begin
                                cmd.op = OP_REJECT;
                                cmd.ev = EV_NOT_SUSPENDED;
                            end
                            else
                            begin
                                cmd.op = OP_UNSUSPEND;
                            end
                        end
                        default:
                        begin
                            cmd.op = OP_NONE;
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                cmd.op = OP_SUSPEND;
            end
            S_SIG_READ:
            begin
                if (stat.rem_zero)
                begin
                    cmd.op = OP_SIG_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_head = 1'b1;
                end
            end
            S_SIG_STEP:
            begin
                cmd.op = OP_SIG_STEP;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/csq_dp.sv
// Datapath: count, thread status, linked wait queue and the result register.
`default_nettype none

module csq_dp #(
    parameter int MAX_THREADS = 16,
    parameter int MAX_SIGNAL  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  csq_pkg::in_word_t  item,
    input  logic               wr_en,
    input  logic [31:0]        wr_data,
    input  csq_pkg::cmd_t      cmd,
    output csq_pkg::stat_t     stat,
    output csq_pkg::out_word_t result,
    output logic               result_valid
);
    import csq_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);

    in_word_t                  item_reg;
    logic signed [COUNT_W-1:0] count_reg;
    logic signed [COUNT_W-1:0] count_next;
    logic [5:0]                rem_reg;
    logic [5:0]                rem_next;
    logic [IW-1:0]             head_reg;
    logic [IW-1:0]             head_next;
    logic [IW-1:0]             tail_reg;
    logic [IW-1:0]             tail_next;
    logic                      empty_reg;
    logic                      empty_next;
    logic [1:0]                status_reg [MAX_THREADS];
    logic [IW-1:0]             next_mem [MAX_THREADS];
    logic [IW-1:0]             prev_mem [MAX_THREADS];
    logic [IW-1:0]             next_rd_reg;
    logic [IW-1:0]             prev_rd_reg;
    out_word_t                 res_reg;
    out_word_t                 res_next;
    logic                      res_valid_reg;
    logic                      res_valid_next;

    logic [IW-1:0]             tid;
    logic [IW-1:0]             rd_addr;
    logic signed [COUNT_W-1:0] count_inc;
    logic signed [COUNT_W-1:0] count_dec;
    logic                      st_we;
    logic [IW-1:0]             st_wa;
    logic [1:0]                st_wd;
    logic                      next_we;
    logic [IW-1:0]             next_wa;
    logic [IW-1:0]             next_wd;
    logic                      prev_we;
    logic [IW-1:0]             prev_wa;
    logic [IW-1:0]             prev_wd;
    logic                      push_en;
    logic                      rm_en;
    logic [IW-1:0]             rm_t;

    assign tid     = IW'(item_reg.thread_id);
    assign rd_addr = cmd.rd_head ? head_reg : tid;

    // Saturating step of the count in either direction.
    assign count_inc = (count_reg == {1'b0, {(COUNT_W-1){1'b1}}}) ? count_reg
                                                                  : count_reg + 32'sd1;
    assign count_dec = (count_reg == {1'b1, {(COUNT_W-1){1'b0}}}) ? count_reg
                                                                  : count_reg - 32'sd1;

    assign stat.action   = action_t'(item_reg.action);
    assign stat.in_range = (32'(item_reg.thread_id) < 32'(MAX_THREADS));
    assign stat.thr_st   = thread_st_t'(status_reg[tid]);
    assign stat.rem_zero = (rem_reg == 6'd0);

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    always_comb
    begin
        count_next     = count_reg;
        rem_next       = rem_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        st_we          = 1'b0;
        st_wa          = tid;
        st_wd          = TS_FREE;
        next_we        = 1'b0;
        next_wa        = tail_reg;
        next_wd        = tid;
        prev_we        = 1'b0;
        prev_wa        = tid;
        prev_wd        = tail_reg;
        push_en        = 1'b0;
        rm_en          = 1'b0;
        rm_t           = tid;
        res_valid_next = 1'b0;
        res_next.event_res     = cmd.ev;
        res_next.result_thread = item_reg.thread_id;
        res_next.new_state     = item_reg.target_state;
        res_next.count_after   = count_reg;
        res_next.last          = 1'b1;

        if (cmd.load_rem)
        begin
            rem_next = (32'(item_reg.signal_amount) > 32'(MAX_SIGNAL)) ? 6'(MAX_SIGNAL)
                                                                       : item_reg.signal_amount;
        end

        case (cmd.op)
            OP_REJECT:
            begin
                res_valid_next = 1'b1;
            end
            OP_WAIT:
            begin
                count_next           = count_dec;
                res_valid_next       = 1'b1;
                res_next.count_after = count_dec;
                if (count_dec[COUNT_W-1])
                begin
                    push_en            = 1'b1;
                    st_we              = 1'b1;
                    st_wd              = TS_WAIT;
                    res_next.event_res = EV_BLOCKED;
                end
                else
                begin
                    res_next.event_res = EV_PROCEEDS;
                end
            end
            OP_SUSPEND:
            begin
                rm_en              = 1'b1;
                st_we              = 1'b1;
                st_wd              = TS_SUSP;
                res_valid_next     = 1'b1;
                res_next.event_res = EV_SUSPENDED;
            end
            OP_UNSUSPEND:
            begin
                push_en            = 1'b1;
                st_we              = 1'b1;
                st_wd              = TS_WAIT;
                res_valid_next     = 1'b1;
                res_next.event_res = EV_UNSUSPENDED;
            end
            OP_SIG_STEP:
            begin
                count_next           = count_inc;
                rem_next             = rem_reg - 6'd1;
                res_next.count_after = count_inc;
                res_next.event_res   = EV_RELEASED;
                res_next.result_thread = THREAD_W'(head_reg);
                res_next.last        = 1'b0;
                if (count_reg[COUNT_W-1] && !empty_reg)
                begin
                    rm_en          = 1'b1;
                    rm_t           = head_reg;
                    st_we          = 1'b1;
                    st_wa          = head_reg;
                    st_wd          = TS_FREE;
                    res_valid_next = 1'b1;
                end
            end
            OP_SIG_DONE:
            begin
                res_valid_next         = 1'b1;
                res_next.event_res     = EV_SIGNAL_DONE;
                res_next.result_thread = '0;
                res_next.new_state     = '0;
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase

        // Append the item's thread at the tail.
        if (push_en)
        begin
            if (empty_reg)
            begin
                head_next  = tid;
                tail_next  = tid;
                empty_next = 1'b0;
            end
            else
            begin
                next_we   = 1'b1;
                next_wa   = tail_reg;
                next_wd   = tid;
                prev_we   = 1'b1;
                prev_wa   = tid;
                prev_wd   = tail_reg;
                tail_next = tid;
            end
        end

        // Unlink a thread; its neighbors were read in the previous cycle.
        if (rm_en)
        begin
            if (head_reg == tail_reg)
            begin
                empty_next = 1'b1;
            end
            else if (rm_t == head_reg)
            begin
                head_next = next_rd_reg;
            end
            else if (rm_t == tail_reg)
            begin
                tail_next = prev_rd_reg;
            end
            else
            begin
                next_we = 1'b1;
                next_wa = prev_rd_reg;
                next_wd = next_rd_reg;
                prev_we = 1'b1;
                prev_wa = next_rd_reg;
                prev_wd = prev_rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                status_reg[i] <= TS_FREE;
            end
        end
        else
        begin
            count_reg     <= wr_en ? wr_data : count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            res_valid_reg <= res_valid_next;
            if (st_we)
            begin
                status_reg[st_wa] <= st_wd;
            end
        end
    end

    // Payload registers and the link memories.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        if (cmd.rd_en)
        begin
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

endmodule

`default_nettype wire

>>> src/counting_semaphore_wait_queue.sv
// Top level of the counting semaphore with a FIFO wait queue of thread ids.
`default_nettype none

// A word is taken when start is high and busy is low. Wait, unsuspend and
// every rejected request keep busy high in the decode state alone; a suspend
// adds the remove state, as the neighbor links of the thread come out of a
// registered read of the link memories before the thread can be unlinked. A
// signal of N repetitions (N clamped to MAX_SIGNAL) keeps busy high through
// decode, a read and a step state per repetition and a final read: each
// repetition reads the link after the queue head, then applies the step. Each
// result word is shown on result for exactly one cycle with result_valid
// high, in the cycle after the step that produced it; the receiver cannot
// stall it, so it must take every word. A signal yields one released word per
// freed thread and then a closing signal-done word with last set; every other
// request yields a single word with last set. Writing wr_data with wr_en loads
// the count, and is allowed only while the block is idle. After reset the
// count is zero, every thread is free and the queue is empty.

module counting_semaphore_wait_queue #(
    parameter int MAX_THREADS = 16,
    parameter int MAX_SIGNAL  = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  csq_pkg::in_word_t  item,
    input  logic               wr_en,
    input  logic [31:0]        wr_data,
    output csq_pkg::out_word_t result,
    output logic               result_valid
);
    import csq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller owns all sequencing; the datapath holds every piece of state
    // that the semaphore keeps between words.
    csq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    csq_dp #(
        .MAX_THREADS (MAX_THREADS),
        .MAX_SIGNAL  (MAX_SIGNAL)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .wr_en        (wr_en),
        .wr_data      (wr_data),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTHESIS
    // The final word of a request is shown only once the block is idle again.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("last result shown while busy");

    // No word can follow the final word in the next cycle.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result directly after last");

    // Only released words come before the closing word of a signal.
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.event_res == EV_RELEASED)
        else $error("non-final result that is not a release");

    // An accepted word always makes the block busy after it is taken.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word left the block idle");
`endif

endmodule

`default_nettype wire
